// ===== rtl/bei_pkg.sv =====
// Breakpoint envelope interpolator: shared types and constants.
// No dependencies.
`default_nettype none
package bei_pkg;
  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW  = 32;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/breakpoint_envelope_interpolator_top.sv =====
// Breakpoint envelope interpolator top level: table memories, sequencer, datapath.
// Depends on bei_pkg and bei_divider.
//
// One item at a time. An insert scans the table linearly (a read state and a check
// state per entry up to the insert point) then shifts later entries up, a read and a
// write state per entry. A query scans to the bracketing pair, does one 33x32
// multiply and a serial divide. Queries on an empty table or outside the table's
// span end after the scan. The single-read-port table memories set the scan rate.
// Results wait in an output register; the next item is taken once it is taken.
`default_nettype none
module breakpoint_envelope_interpolator_top #(
  parameter int unsigned TABLE_DEPTH = bei_pkg::TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // time_stamp, point_value, fallback_value
  input  wire logic        s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // result_value
  output logic             m_tuser   // status
);
  import bei_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  logic [TimeW-1:0] tmem [TABLE_DEPTH];
  logic [ValW-1:0]  vmem [TABLE_DEPTH];
  logic [TimeW-1:0] trd;
  logic [ValW-1:0]  vrd;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  logic [TimeW-1:0] wt;
  logic [ValW-1:0]  wv;

  always_ff @(posedge clk) begin
    if (we) begin
      tmem[waddr] <= wt;
      vmem[waddr] <= wv;
    end
    trd <= tmem[raddr];
    vrd <= vmem[raddr];
  end

  state_t state, state_next;
  logic [CW-1:0]    count, idx, pos;
  logic             cmd;
  logic [31:0]      t_in, pv, fb;
  logic [31:0]      tl, tr;
  logic [31:0]      vl, vr;
  logic [32:0]      mag;
  logic             neg;
  logic [63:0]      prod;
  logic [31:0]      frac, width;
  logic [31:0]      res;
  logic             stat;
  logic             div_start;
  div_ctrl_t        dctrl;
  logic [31:0]      quot;

  assign prod = {31'b0, mag} * {32'b0, frac};

  bei_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor({1'b0, width}), .ctrl(dctrl), .quotient(quot)
  );

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid && s_tready) state_next = ST_SCAN_RD;
      ST_SCAN_RD:  state_next = (idx == count) ?
                                  ((cmd == CmdQuery || count == DepthC) ? ST_DONE : ST_PUT) :
                                  ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (cmd == CmdQuery) begin
          if (idx == '0 && t_in <= trd) state_next = ST_DONE;
          else if (trd > t_in) state_next = ST_Q_RD0;
          else if (idx == count - CW'(1)) state_next = ST_DONE;
          else state_next = ST_SCAN_RD;
        end else if (trd >= t_in) begin
          if (trd == t_in) state_next = ST_DONE;
          else if (count == DepthC) state_next = ST_DONE;
          else state_next = ST_SHIFT_RD;
        end else state_next = ST_SCAN_RD;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = (idx == pos + CW'(1)) ? ST_PUT : ST_SHIFT_RD;
      ST_PUT:      state_next = ST_DONE;
      ST_Q_RD0:    state_next = ST_Q_RD1;
      ST_Q_RD1:    state_next = ST_Q_PREP;
      ST_Q_PREP:   state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV;
      ST_DIV:      if (!dctrl.busy && !dctrl.start) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    raddr = idx[AW-1:0];
    we = 1'b0;
    waddr = idx[AW-1:0];
    wt = t_in;
    wv = pv;
    div_start = (state == ST_MUL);
    case (state)
      ST_SHIFT_RD: raddr = AW'(idx - CW'(1));
      ST_SHIFT_WR: begin
        we = 1'b1;
        wt = trd;
        wv = vrd;
      end
      ST_PUT: we = 1'b1;
      ST_Q_RD0: raddr = AW'(idx - CW'(1));
      default: ;
    endcase
    if (state == ST_SCAN_CHK && cmd == CmdInsert && trd == t_in) begin
      we = 1'b1;
      wt = t_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_DONE) m_tvalid <= 1'b1;
      if (state == ST_SCAN_CHK && cmd == CmdInsert && trd > t_in && count != DepthC)
        count <= count + CW'(1);
      if (state == ST_SCAN_RD && idx == count && cmd == CmdInsert && count != DepthC)
        count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd  <= s_tuser;
        t_in <= s_tdata[31:0];
        pv   <= s_tdata[63:32];
        fb   <= s_tdata[95:64];
        idx  <= '0;
        res  <= '0;
        stat <= 1'b0;
      end
      ST_SCAN_RD: begin
        if (idx == count) begin
          if (cmd == CmdQuery) res <= (count == '0) ? fb : vl;
          else if (count == DepthC) stat <= 1'b1;
          else idx <= count;
        end
      end
      ST_SCAN_CHK: begin
        vl <= vrd;
        if (cmd == CmdQuery) begin
          tr <= trd;
          vr <= vrd;
          if (idx == '0 && t_in <= trd) begin
            res <= vrd;
            idx <= CW'(1);
          end else if (idx != '0 && trd > t_in) begin
            // bracket found at idx
          end else if (idx == count - CW'(1)) begin
            res <= vrd;
          end else idx <= idx + CW'(1);
        end else if (trd >= t_in) begin
          if (trd != t_in && count == DepthC) stat <= 1'b1;
          else if (trd != t_in) begin
            pos <= idx;
            idx <= count;
          end
        end else idx <= idx + CW'(1);
      end
      ST_SHIFT_WR: idx <= idx - CW'(1);
      ST_Q_RD1: begin
        tl <= trd;
        vl <= vrd;
      end
      ST_Q_PREP: begin
        frac  <= t_in - tl;
        width <= tr - tl;
        neg   <= $signed(vr) < $signed(vl);
        mag   <= ($signed(vr) < $signed(vl)) ?
                 33'({vl[31], vl} - {vr[31], vr}) : 33'({vr[31], vr} - {vl[31], vl});
      end
      ST_DIV: if (!dctrl.busy && !dctrl.start)
                res <= neg ? (vl - quot) : (vl + quot);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      m_tdata <= (cmd == CmdQuery) ? res : '0;
      m_tuser <= stat;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bei_divider.sv =====
// Serial restoring divider: 64-bit dividend over 33-bit divisor, one bit per cycle.
// Depends on bei_pkg.
`default_nettype none
module bei_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       dividend,
  input  wire logic [32:0]       divisor,
  output bei_pkg::div_ctrl_t     ctrl,
  output logic [31:0]            quotient
);
  import bei_pkg::*;

  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] shifted;
  logic [34:0] diff;

  assign shifted = {rem[32:0], quo[63]};
  assign diff = {1'b0, shifted} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[34]) begin
        rem <= diff[33:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // quotient fits in 32 bits since frac < width
  assign quotient   = quo[31:0];
  assign ctrl.start = start;
  assign ctrl.busy  = busy;
endmodule
`default_nettype wire

// ===== dv/bei_checker.sv =====
// Checker for the breakpoint envelope interpolator: watches both streams,
// keeps its own breakpoint table, predicts each result and compares.
// Depends on bei_pkg.
`timescale 1ns / 100ps
module bei_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [95:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic        m_tuser,
  output int               fail_count,
  output int               pending
);
  import bei_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        refused;
  } answer_t;

  logic [31:0] tbl_time [DEPTH];
  logic [31:0] tbl_val  [DEPTH];
  int unsigned tbl_n;
  answer_t     answers [$];

  function automatic logic [31:0] envelope_at(logic [31:0] t, logic [31:0] fb);
    int unsigned hi;
    longint lv, rv, diff;
    logic [63:0] mag, frac, span, q;
    if (tbl_n == 0) return fb;
    if (t <= tbl_time[0]) return tbl_val[0];
    if (t >= tbl_time[tbl_n-1]) return tbl_val[tbl_n-1];
    hi = 1;
    while (hi < tbl_n - 1 && tbl_time[hi] <= t) hi++;
    span = {32'd0, tbl_time[hi]} - {32'd0, tbl_time[hi-1]};
    frac = {32'd0, t} - {32'd0, tbl_time[hi-1]};
    lv = longint'($signed(tbl_val[hi-1]));
    rv = longint'($signed(tbl_val[hi]));
    diff = rv - lv;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    q = (mag * frac) / span;
    if (diff < 0) return 32'(lv - longint'(q));
    return 32'(lv + longint'(q));
  endfunction

  function automatic logic place_point(logic [31:0] t, logic [31:0] v);
    int unsigned pos;
    pos = 0;
    while (pos < tbl_n && tbl_time[pos] < t) pos++;
    if (pos < tbl_n && tbl_time[pos] == t) begin
      tbl_val[pos] = v;
      return 1'b0;
    end
    if (tbl_n >= DEPTH) return 1'b1;
    for (int k = tbl_n; k > pos; k--) begin
      tbl_time[k] = tbl_time[k-1];
      tbl_val[k] = tbl_val[k-1];
    end
    tbl_time[pos] = t;
    tbl_val[pos] = v;
    tbl_n++;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    answer_t a, e;
    if (rst) begin
      tbl_n = 0;
      answers.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == CmdQuery) begin
          a.value = envelope_at(s_tdata[31:0], s_tdata[95:64]);
          a.refused = 1'b0;
        end else begin
          a.value = '0;
          a.refused = place_point(s_tdata[31:0], s_tdata[63:32]);
        end
        answers = {answers, a};
      end
      if (m_tvalid && m_tready) begin
        if (answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result value=%h status=%b", m_tdata, m_tuser);
        end else begin
          e = answers.pop_front();
          if (e.value !== m_tdata || e.refused !== m_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp value=%h status=%b, got value=%h status=%b",
                       e.value, e.refused, m_tdata, m_tuser);
          end
        end
      end
      pending = answers.size();
    end
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the interpolator testbench: clock, reset, stimulus, stalls, verdict.
// Depends on bei_pkg, bei_checker and the breakpoint_envelope_interpolator_top RTL.
`timescale 1ns / 100ps
module testbench;
  import bei_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        s_tuser = CmdInsert;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] used_times [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  breakpoint_envelope_interpolator_top u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  bei_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [31:0] t, logic [31:0] v, logic [31:0] fb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {fb, v, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time();
    if (used_times.size() > 0 && $urandom_range(3) == 0)
      return used_times[$urandom_range(used_times.size() - 1)];
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(4000);
      2: return 32'hFFFF_FFFF - $urandom_range(4000);
      default: return $urandom_range(32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  task automatic insert_point(logic [31:0] t, logic [31:0] v);
    used_times = {used_times, t};
    send_item(CmdInsert, t, v, $urandom());
  endtask

  initial begin
    logic [31:0] t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty table, fallback extremes
    send_item(CmdQuery, 32'h0, $urandom(), 32'h8000_0000);
    send_item(CmdQuery, 32'hFFFF_FFFF, $urandom(), 32'h7FFF_FFFF);
    insert_point(32'h0000_1000, 32'h8000_0000);
    insert_point(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    insert_point(32'h0000_0000, 32'h0000_0005);
    insert_point(32'h0000_1000, 32'h7FFF_FFFF);  // replace value at same time
    send_item(CmdQuery, 32'h0, 0, 0);
    send_item(CmdQuery, 32'h0000_0800, 0, 0);
    send_item(CmdQuery, 32'h0000_1000, 0, 0);
    send_item(CmdQuery, 32'h8000_0000, 0, 0);
    send_item(CmdQuery, 32'hFFFF_FFFE, 0, 0);
    send_item(CmdQuery, 32'hFFFF_FFFF, 0, 0);
    insert_point(32'h0000_2000, 32'h8000_0000);
    send_item(CmdQuery, 32'h0000_1801, 0, 0);
    // fill the table to see a refusal, then replace while full
    for (int i = 0; i < 62; i++) insert_point(32'h0001_0000 + i * 32'h100, $urandom());
    send_item(CmdInsert, 32'h0000_0003, 32'h1234, 0);
    send_item(CmdInsert, 32'h0000_2000, 32'h7FFF_0000, 0);
    send_item(CmdQuery, 32'h0000_1FFF, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 23 : 73) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 23 : 73) : 0;
      for (int i = 0; i < 293; i++) begin
        if (i % 100 == 0) begin
          // restart with a fresh table: drain, then reset is not allowed,
          // so instead keep the filled table but vary the queries
        end
        if ($urandom_range(2) == 0) begin
          t = pick_time();
          if ($urandom_range(1)) used_times = {used_times, t};
          send_item(CmdInsert, t, pick_value(), $urandom());
        end else begin
          send_item(CmdQuery, pick_time(), $urandom(), $urandom());
        end
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bei_pkg.sv
rtl/bei_divider.sv
rtl/breakpoint_envelope_interpolator_top.sv
dv/bei_checker.sv
dv/testbench.sv
